FILE: design/bad_pkg.sv
package bad_pkg;

  localparam int DIST_W    = 10;
  localparam int SUM_W     = 14;
  localparam int FRAC_W    = 8;
  localparam int EVENT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP   = 2'd1;

  localparam logic [FRAC_W-1:0] DROP_FRAC_RST = 8'd102;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2
  } motion_event_e;

endpackage

FILE: design/bad_if.sv
interface bad_sample_if;
  import bad_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, output distance_cm, input ready);
  modport sink   (input valid, input distance_cm, output ready);
endinterface

interface bad_result_if;
  import bad_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  block_average;
  logic [EVENT_W-1:0] motion_event;
  logic               motion_active;

  modport source (output valid, output block_average, output motion_event,
                  output motion_active, input ready);
  modport sink   (input valid, input block_average, input motion_event,
                  input motion_active, output ready);
endinterface

FILE: design/block_average_drop_detector_top.sv
// block average drop detector
// sample_i carries one distance sample per transaction (valid/ready). samples are
// summed in blocks of BLOCK_LEN; the sample that closes a block produces exactly one
// transaction on result_o with the floor of the block mean, the motion event
// (none, started, ended) and the motion flag after the decision. other samples
// produce nothing. with enable cleared, samples are taken and dropped unchanged.
// a closing sample's sum is registered in the block sum register, and the mean,
// event and flag are then registered in the result register. samples are taken
// one per cycle while sample_i.ready is high.
// when the receiver stalls the result register holds; the block sum register still
// takes one more closing block and samples keep flowing until both are full, then
// sample_i.ready drops until the result is taken.
// config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the next edge; the user
// must write only while idle (not enforced by the block); unknown indexes are ignored.
// reset (rst_ni low, asynchronous): enable 1, drop fraction 102/256, empty block,
// previous mean 0, no motion, no pending results.
module block_average_drop_detector_top #(
  parameter int BLOCK_LEN = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bad_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bad_pkg::CFG_W-1:0]     cfg_data_i,
  bad_sample_if.sink                  sample_i,
  bad_result_if.source                result_o
);
  import bad_pkg::*;

  // count width, at least one bit
  localparam int CNT_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

  // mean by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int DIV_SH  = SUM_W + 5;
  localparam int RECIP_W = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** DIV_SH + BLOCK_LEN - 1) / BLOCK_LEN);
  localparam int MUL_W   = SUM_W + RECIP_W;
  localparam int CMP_W   = DIST_W + FRAC_W;

  // configuration
  logic              enable_q;
  logic [FRAC_W-1:0] frac_q;

  // accumulator
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d, sum_nxt;

  // completed block sum stage
  logic              blk_vld_q, blk_vld_d;
  logic [SUM_W-1:0]  blk_sum_q;

  // decision state
  logic [DIST_W-1:0] prev_q;
  logic              motion_q, motion_d;

  // result register
  logic               out_vld_q, out_vld_d;
  logic [DIST_W-1:0]  out_avg_q;
  motion_event_e      out_ev_q, ev_d;
  logic               out_act_q;

  logic accept, block_done, out_free, s1_free, s2_move;

  logic [MUL_W-1:0]  mean_prod;
  logic [DIST_W-1:0] avg;
  logic [DIST_W-1:0] diff;
  logic [CMP_W-1:0]  drop_lhs, drop_rhs;

  // handshakes
  assign out_free = !out_vld_q || result_o.ready;
  assign s1_free  = !blk_vld_q || out_free;
  assign s2_move  = blk_vld_q && out_free;

  assign sample_i.ready = s1_free;
  assign accept         = sample_i.valid && s1_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      frac_q   <= DROP_FRAC_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ENABLE) begin
        enable_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == CFG_DROP) begin
        frac_q <= cfg_data_i[FRAC_W-1:0];
      end
    end
  end

  // accumulate samples, hand the closing sum to the mean stage
  assign sum_nxt    = sum_q + SUM_W'(sample_i.distance_cm);
  assign block_done = accept && enable_q && (count_q == CNT_LAST);

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept && enable_q) begin
      if (block_done) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
        sum_d   = sum_nxt;
      end
    end
  end

  assign blk_vld_d = block_done || (blk_vld_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      blk_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      sum_q     <= sum_d;
      blk_vld_q <= blk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (block_done) begin
      blk_sum_q <= sum_nxt;
    end
  end

  // mean and drop decision
  assign mean_prod = MUL_W'(blk_sum_q) * MUL_W'(RECIP);
  assign avg       = mean_prod[DIV_SH +: DIST_W];
  assign diff      = prev_q - avg;
  assign drop_lhs  = {diff, {FRAC_W{1'b0}}};
  assign drop_rhs  = CMP_W'(prev_q) * CMP_W'(frac_q);

  always_comb begin
    motion_d = motion_q;
    ev_d     = EV_NONE;
    priority if ((prev_q > avg) && (drop_lhs > drop_rhs)) begin
      motion_d = 1'b1;
      ev_d     = EV_START;
    end else if (motion_q && (prev_q < avg)) begin
      motion_d = 1'b0;
      ev_d     = EV_END;
    end else begin
      // no change of motion state
      motion_d = motion_q;
      ev_d     = EV_NONE;
    end
  end

  assign out_vld_d = s2_move || (out_vld_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      motion_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (s2_move) begin
        prev_q   <= avg;
        motion_q <= motion_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_avg_q <= avg;
      out_ev_q  <= ev_d;
      out_act_q <= motion_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.block_average = out_avg_q;
  assign result_o.motion_event  = out_ev_q;
  assign result_o.motion_active = out_act_q;

endmodule

FILE: design/bad_checker.sv
module bad_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bad_pkg::EVENT_W-1:0] out_event_i,
  input logic                        out_active_i
);
  import bad_pkg::*;

  // nothing pending while in reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // a start leaves motion active
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_event_i == EV_START) |-> out_active_i)
    else $error("motion start without active flag");

  // an end leaves motion inactive
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_event_i == EV_END) |-> !out_active_i)
    else $error("motion end with active flag");

  // only defined event codes
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_event_i == EV_NONE) || (out_event_i == EV_START) ||
                    (out_event_i == EV_END))
    else $error("undefined motion event code");

endmodule

bind block_average_drop_detector_top bad_checker u_bad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_event_i  (result_o.motion_event),
  .out_active_i (result_o.motion_active)
);

FILE: sim/bad_drop_checker.sv
module bad_drop_checker
  import bad_pkg::*;
#(
  parameter int BLOCK_LEN = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bad_sample_if                sample_mon,
  bad_result_if                result_mon,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   starts_o,
  output int                   ends_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIST_W-1:0] mean;
    motion_event_e     ev;
    logic              active;
  } block_result_t;

  block_result_t mean_q[$];

  logic              en_q;
  logic [FRAC_W-1:0] frac_q;
  logic [3:0]        fill_cnt;
  logic [SUM_W-1:0]  run_sum;
  logic [DIST_W-1:0] prior_mean;
  logic              motion_on;

  function automatic bit field_matches(string field, logic [DIST_W-1:0] want,
                                       logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // accumulate one sample, predict the block result when it closes a block
  task automatic take_sample(input logic [DIST_W-1:0] d);
    logic [SUM_W-1:0]  sum_next;
    logic [DIST_W-1:0] mean;
    block_result_t     r;
    if (!en_q) return;
    sum_next = run_sum + SUM_W'(d);
    if (int'(fill_cnt) + 1 < BLOCK_LEN) begin
      fill_cnt = fill_cnt + 4'd1;
      run_sum  = sum_next;
      return;
    end
    mean     = DIST_W'(int'(sum_next) / BLOCK_LEN);
    fill_cnt = '0;
    run_sum  = '0;
    r.ev     = EV_NONE;
    // relative drop compared exactly in q0.8 terms
    if (prior_mean > mean &&
        ((int'(prior_mean) - int'(mean)) << FRAC_W) > int'(prior_mean) * int'(frac_q)) begin
      motion_on = 1'b1;
      r.ev      = EV_START;
      starts_o++;
    end else if (motion_on && prior_mean < mean) begin
      motion_on = 1'b0;
      r.ev      = EV_END;
      ends_o++;
    end
    prior_mean = mean;
    r.mean     = mean;
    r.active   = motion_on;
    mean_q.push_back(r);
  endtask

  task automatic check_result();
    block_result_t want;
    if (mean_q.size() == 0) begin
      $error("unexpected result: block_average %0d motion_event %0d motion_active %0d",
             result_mon.block_average, result_mon.motion_event, result_mon.motion_active);
      fail_count_o++;
      return;
    end
    want = mean_q.pop_front();
    checked_o++;
    if (!field_matches("block_average", want.mean, result_mon.block_average))
      fail_count_o++;
    if (!field_matches("motion_event", DIST_W'(want.ev), DIST_W'(result_mon.motion_event)))
      fail_count_o++;
    if (!field_matches("motion_active", DIST_W'(want.active),
                       DIST_W'(result_mon.motion_active)))
      fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q.delete();
      en_q         = 1'b1;
      frac_q       = DROP_FRAC_RST;
      fill_cnt     = '0;
      run_sum      = '0;
      prior_mean   = '0;
      motion_on    = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      starts_o     = 0;
      ends_o       = 0;
    end else begin
      // results first, so a result never meets the sample taken at the same edge
      if (result_mon.valid && result_mon.ready) check_result();
      if (sample_mon.valid && sample_mon.ready) take_sample(sample_mon.distance_cm);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE: en_q = cfg_data_i[0];
          CFG_DROP:   frac_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = mean_q.size();
    end
  end

endmodule

FILE: sim/tb_block_average_drop_detector_top.sv
module tb_block_average_drop_detector_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bad_pkg::*;

  localparam int BLOCK_LEN     = 15;
  localparam int DIST_MAX      = (1 << DIST_W) - 1;
  localparam int GAP_PCT       = 21;   // chance of an idle cycle on either side
  localparam int SETTLE_CYCLES = 4;    // margin for a result still in flight
  localparam int END_WAIT      = 5000; // cycles allowed for the last results
  localparam int PHASE_SAMPLES = 175;
  localparam int N_PHASES      = 10;

  // indexes the block does not decode, writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i;
  logic                 rst_ni = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  bad_sample_if sample_bus ();
  bad_result_if result_bus ();

  // stimulus controls; rx_gaps_on and rx_hold_cycles are shared with the result sink process
  bit tx_gaps_on     = 1'b1;
  bit rx_gaps_on     = 1'b1;
  int rx_hold_cycles = 0;
  int samples_sent   = 0;
  int stim_level     = 500;

  // from the checker
  int fail_count;
  int pending;
  int checked;
  int starts;
  int ends;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  block_average_drop_detector_top #(
    .BLOCK_LEN (BLOCK_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (sample_bus),
    .result_o   (result_bus)
  );

  bad_drop_checker #(
    .BLOCK_LEN (BLOCK_LEN)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .sample_mon   (sample_bus),
    .result_mon   (result_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .starts_o     (starts),
    .ends_o       (ends)
  );

  function automatic int clamp_dist(int v);
    if (v < 0) return 0;
    if (v > DIST_MAX) return DIST_MAX;
    return v;
  endfunction

  // offer one sample and hold it until the transaction completes
  task automatic send_sample(input logic [DIST_W-1:0] d);
    while (tx_gaps_on && $urandom_range(99) < GAP_PCT) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.distance_cm <= d;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    samples_sent++;
  endtask

  // one block's worth of samples scattered around a centre value
  task automatic send_block(input int centre, input int spread);
    int v;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      v = centre + int'($urandom_range(2 * spread)) - spread;
      send_sample(DIST_W'(clamp_dist(v)));
    end
  endtask

  // stop offering and let every outstanding result drain before going on
  task automatic drain();
    sample_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a non-closing sample may still be in the accumulator
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // mostly whole blocks following a drifting level, so drops and recoveries
  // actually trip the detector; now and then a burst of noise of odd length
  // that knocks the blocks out of step
  task automatic random_block();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, BLOCK_LEN)) send_sample(DIST_W'($urandom_range(DIST_MAX)));
      return;
    end
    if (pick < 15)
      stim_level = $urandom_range(1) ? DIST_MAX : 0;
    else if (pick < 50)
      stim_level = stim_level * int'($urandom_range(100)) / 100;
    else if (pick < 80)
      stim_level = clamp_dist(stim_level + int'($urandom_range(1, 300)));
    else
      stim_level = clamp_dist(stim_level + int'($urandom_range(20)) - 10);
    send_block(stim_level, $urandom_range(3) == 0 ? int'($urandom_range(60))
                                                   : int'($urandom_range(4)));
  endtask

  // result side: random back-pressure, or a long hold-off when asked for
  initial begin : result_sink
    result_bus.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        result_bus.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        result_bus.ready <= !(rx_gaps_on && $urandom_range(99) < GAP_PCT);
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] frac_plan [6];
    logic [CFG_W-1:0] frac;
    int               phase_end;
    int               waited;

    frac_plan              = '{8'd0, 8'd255, 8'd102, 8'd1, 8'd128, 8'd200};
    sample_bus.valid       = 1'b0;
    sample_bus.distance_cm = '0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_ENABLE;
    cfg_data               = '0;

    // reset goes low before the first clock edge, so every register with a reset is defined there
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, starting on the reset settings
    send_block(DIST_MAX, 0);  // first block: nothing to compare against
    send_block(0, 0);         // full drop, motion starts
    send_block(0, 0);         // level, motion stays on with no event
    send_block(256, 0);       // rise while active, motion ends
    send_block(154, 0);       // drop of exactly 102/256, must not start

    write_reg(CFG_SPARE_A, 8'h00);
    write_reg(CFG_SPARE_B, 8'h00);

    // disabled: upper data bits set, enable bit clear
    write_reg(CFG_ENABLE, 8'hFE);
    for (int i = 0; i < 7; i++) send_sample(i[0] ? DIST_W'(DIST_MAX) : '0);
    write_reg(CFG_ENABLE, 8'hFF);

    send_block(1000, 0);
    send_block(100, 0);       // motion starts
    send_block(10, 0);        // drops again while active, start reported again
    send_block(DIST_MAX, 0);  // motion ends

    write_reg(CFG_DROP, 8'd0);
    send_block(DIST_MAX - 1, 0);  // any drop at all starts motion
    write_reg(CFG_DROP, 8'd255);
    send_block(DIST_MAX, 0);
    send_block(1, 0);             // near-total drop still beats 255/256

    // random part, one drop fraction per phase
    for (int phase = 0; phase < N_PHASES; phase++) begin
      frac = (phase < 6) ? frac_plan[phase] : CFG_W'($urandom_range(255));
      write_reg(CFG_DROP, frac);
      // one phase runs flat out on both sides
      tx_gaps_on = (phase != 3);
      rx_gaps_on = (phase != 3);
      if (phase == 7) begin
        write_reg(CFG_ENABLE, CFG_W'($urandom_range(127) << 1));
        repeat (30) send_sample(DIST_W'($urandom_range(DIST_MAX)));
        write_reg(CFG_ENABLE, CFG_W'($urandom_range(255) | 1));
      end
      // receiver holds off while samples keep coming, so the block fills and stalls
      if (phase == 5) rx_hold_cycles = 300;
      phase_end = samples_sent + PHASE_SAMPLES;
      while (samples_sent < phase_end) random_block();
    end

    sample_bus.valid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d samples sent, %0d block results checked, %0d motion starts, %0d ends",
             samples_sent, checked, starts, ends);
    $display("covered drop fractions 0 to 255, enable toggling, spare indexes, back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("timeout: %0d transactions still expected", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
